[design/prb_pkg.sv]
// Shared types and constants of the palette rotating pixel blitter.
package prb_pkg;

	localparam int ADDR_W = 18;
	localparam int COLOR_W = 16;
	localparam int DIM_W = 9;
	localparam int REG_IDX_W = 3;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_PALETTE = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROTATION = 3'd0,
		REG_SCREEN_WIDTH = 3'd1,
		REG_SCREEN_HEIGHT = 3'd2,
		REG_FRAME_LEFT = 3'd3,
		REG_FRAME_TOP = 3'd4,
		REG_FRAME_COLUMNS = 3'd5,
		REG_FRAME_ROWS = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		ROT_0 = 2'd0,
		ROT_90 = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef struct packed {
		rot_t rotation;
		logic [DIM_W-1:0] screen_width;
		logic [DIM_W-1:0] screen_height;
		logic [DIM_W-1:0] frame_left;
		logic [DIM_W-1:0] frame_top;
		logic [DIM_W-1:0] frame_columns;
		logic [DIM_W-1:0] frame_rows;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] mul_a;
		logic [ADDR_W-1:0] add_b;
	} op_t;

	localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH = 9'd320;
	localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 9'd240;
	localparam logic [DIM_W-1:0] RST_FRAME_LEFT = 9'd32;
	localparam logic [DIM_W-1:0] RST_FRAME_TOP = 9'd0;
	localparam logic [DIM_W-1:0] RST_FRAME_COLUMNS = 9'd256;
	localparam logic [DIM_W-1:0] RST_FRAME_ROWS = 9'd240;

endpackage

[design/prb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/prb_cfg.sv]
// Configuration register bank of the blitter.
module prb_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_enable,
	input  logic [prb_pkg::REG_IDX_W-1:0]  write_index,
	input  logic [prb_pkg::DIM_W-1:0]      write_data,
	output prb_pkg::cfg_t                  cfg
);

	import prb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation <= ROT_0;
			cfg_q.screen_width <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
			cfg_q.frame_left <= RST_FRAME_LEFT;
			cfg_q.frame_top <= RST_FRAME_TOP;
			cfg_q.frame_columns <= RST_FRAME_COLUMNS;
			cfg_q.frame_rows <= RST_FRAME_ROWS;
		end else if (write_enable) begin
			unique case (reg_index_t'(write_index))
				REG_ROTATION: cfg_q.rotation <= rot_t'(write_data[1:0]);
				REG_SCREEN_WIDTH: cfg_q.screen_width <= write_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= write_data;
				REG_FRAME_LEFT: cfg_q.frame_left <= write_data;
				REG_FRAME_TOP: cfg_q.frame_top <= write_data;
				REG_FRAME_COLUMNS: cfg_q.frame_columns <= write_data;
				REG_FRAME_ROWS: cfg_q.frame_rows <= write_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/prb_raster.sv]
// Raster position counters and rotation operand selection.
module prb_raster (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  prb_pkg::cfg_t   cfg,
	output prb_pkg::op_t    op,
	output logic            done
);

	import prb_pkg::*;

	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             col_wrap;
	logic             row_wrap;
	logic [ADDR_W-1:0] px;
	logic [ADDR_W-1:0] py;
	logic [ADDR_W-1:0] flip_x;
	logic [ADDR_W-1:0] flip_y;

	assign col_inc = col_q + 9'd1;
	assign row_inc = row_q + 9'd1;
	assign col_wrap = (col_inc >= cfg.frame_columns) || (col_inc == '0);
	assign row_wrap = (row_inc >= cfg.frame_rows) || (row_inc == '0);
	assign done = col_wrap && row_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc;
			end else begin
				col_q <= col_inc;
			end
		end
	end

	always_comb begin
		px = {9'd0, cfg.frame_left} + {9'd0, col_q};
		py = {9'd0, cfg.frame_top} + {9'd0, row_q};
		flip_x = {9'd0, cfg.screen_width} - 18'd1 - px;
		flip_y = {9'd0, cfg.screen_height} - 18'd1 - py;
		unique case (cfg.rotation)
			ROT_0: begin
				op.mul_a = py;
				op.add_b = px;
			end
			ROT_90: begin
				op.mul_a = px;
				op.add_b = flip_y;
			end
			ROT_180: begin
				op.mul_a = flip_y;
				op.add_b = flip_x;
			end
			ROT_270: begin
				op.mul_a = flip_x;
				op.add_b = py;
			end
			default: begin
				op.mul_a = py;
				op.add_b = px;
			end
		endcase
	end

endmodule

[design/prb_addr.sv]
// Framebuffer address multiply-add with the canvas width as stride.
module prb_addr (
	input  prb_pkg::op_t                 op,
	input  logic [prb_pkg::DIM_W-1:0]    stride,
	output logic [prb_pkg::ADDR_W-1:0]   address
);

	import prb_pkg::*;

	logic [ADDR_W+DIM_W-1:0] product;

	assign product = op.mul_a * stride;
	assign address = product[ADDR_W-1:0] + op.add_b;

endmodule

[design/palette_rotating_pixel_blitter.sv]
// Top level of the palette rotating pixel blitter.
// The block takes one word per clock on the input channel while in_stall is
// low. A palette write stores the RGB565 form of its color at the given index
// and gives no result; a pixel word gives one result, with the palette color,
// the framebuffer address for the current rotation and a frame_done flag on
// the last pixel of the frame. Stage s1 is the palette RAM's registered read
// together with the raster operand register; stage s2 is the address
// multiply-add into the output register. A pixel may follow a palette write to
// the same index in the next cycle and sees the new color. The user must write
// configuration only while no pixel is in flight; the block does not enforce it.
module palette_rotating_pixel_blitter #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          write_enable,
	input  logic [prb_pkg::REG_IDX_W-1:0] write_index,
	input  logic [prb_pkg::DIM_W-1:0]     write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [7:0]                    code,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [prb_pkg::ADDR_W-1:0]    pixel_address,
	output logic [prb_pkg::COLOR_W-1:0]   pixel_color,
	output logic                          frame_done
);

	import prb_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	cfg_t              cfg;
	op_t               op;
	logic              done;
	logic              in_accept;
	logic              pix_accept;
	logic              code_ok;
	logic [IDX_W-1:0]  pal_idx;
	logic [COLOR_W-1:0] pal_color;
	logic [COLOR_W-1:0] pal_rd_data;
	logic              s1_adv;
	logic [ADDR_W-1:0] address;

	logic              valid_s1;
	op_t               op_s1;
	logic              done_s1;
	logic              hit_s1;

	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [COLOR_W-1:0] color_s2;
	logic              done_s2;

	assign in_accept = in_valid && !in_stall;
	assign pix_accept = in_accept && (action == ACT_PIXEL);
	assign code_ok = int'(code) < PALETTE_ENTRIES;
	assign pal_idx = code[IDX_W-1:0];
	assign pal_color = {red[7:3], green[7:2], blue[7:3]};

	assign s1_adv = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;

	prb_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	prb_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (pix_accept),
		.cfg     (cfg),
		.op      (op),
		.done    (done)
	);

	prb_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (in_accept && (action == ACT_PALETTE) && code_ok),
		.wr_addr (pal_idx),
		.wr_data (pal_color),
		.rd_en   (pix_accept),
		.rd_addr (pal_idx),
		.rd_data (pal_rd_data)
	);

	prb_addr u_addr (
		.op      (op_s1),
		.stride  (cfg.screen_width),
		.address (address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= pix_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			op_s1 <= op;
			done_s1 <= done;
			hit_s1 <= code_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			addr_s2 <= address;
			color_s2 <= hit_s1 ? pal_rd_data : '0;
			done_s2 <= done_s1;
		end
	end

	assign out_valid = valid_s2;
	assign pixel_address = addr_s2;
	assign pixel_color = color_s2;
	assign frame_done = done_s2;

	// A palette write never leaves a word in the first stage.
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (action == ACT_PALETTE) |=> !valid_s1)
		else $error("palette write produced a pipeline word");

	// The palette read data must hold while the first stage waits.
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> $stable(pal_rd_data) && valid_s1)
		else $error("palette read data changed under a stalled word");

	// The last pixel of a frame returns the raster to the origin.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept && done |=> (u_raster.col_q == '0) && (u_raster.row_q == '0))
		else $error("raster did not return to origin after frame end");

	// A word leaves the first stage only into a free or draining output.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall && valid_s1 |=> valid_s2 && valid_s1)
		else $error("pipeline word lost under output stall");

endmodule

[verif/palette_rotating_pixel_blitter_test.sv]
// Self-checking testbench of the palette rotating pixel blitter with a scoreboard class.
`timescale 1ns / 100ps

module palette_rotating_pixel_blitter_test;
	import prb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 11;
	localparam int WORDS_PER_PHASE = 145;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [COLOR_W-1:0] color;
		logic done;
	} pixel_t;

	class pixel_scoreboard;
		cfg_t cfg;
		logic [COLOR_W-1:0] palette [256];
		logic [DIM_W-1:0] column;
		logic [DIM_W-1:0] row;
		pixel_t expected [$];
		int mismatches;

		function new();
			cfg = '{ROT_0, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_FRAME_LEFT,
				RST_FRAME_TOP, RST_FRAME_COLUMNS, RST_FRAME_ROWS};
			column = '0;
			row = '0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [DIM_W-1:0] data);
			case (idx)
				REG_ROTATION: cfg.rotation = rot_t'(data[1:0]);
				REG_SCREEN_WIDTH: cfg.screen_width = data;
				REG_SCREEN_HEIGHT: cfg.screen_height = data;
				REG_FRAME_LEFT: cfg.frame_left = data;
				REG_FRAME_TOP: cfg.frame_top = data;
				REG_FRAME_COLUMNS: cfg.frame_columns = data;
				REG_FRAME_ROWS: cfg.frame_rows = data;
				default: ;
			endcase
		endfunction

		function void note_word(logic act, logic [7:0] cd, logic [7:0] r, logic [7:0] g,
				logic [7:0] b);
			logic [ADDR_W-1:0] px, py, w, h, addr;
			pixel_t item;
			if (act == ACT_PALETTE) begin
				palette[cd] = {r[7:3], g[7:2], b[7:3]};
			end else begin
				px = ADDR_W'(cfg.frame_left) + ADDR_W'(column);
				py = ADDR_W'(cfg.frame_top) + ADDR_W'(row);
				w = ADDR_W'(cfg.screen_width);
				h = ADDR_W'(cfg.screen_height);
				case (cfg.rotation)
					ROT_0: addr = py * w + px;
					ROT_90: addr = px * w + (h - 18'd1 - py);
					ROT_180: addr = (h - 18'd1 - py) * w + (w - 18'd1 - px);
					default: addr = (w - 18'd1 - px) * w + py;
				endcase
				item.addr = addr;
				item.color = palette[cd];
				item.done = 1'b0;
				column = column + 9'd1;
				if (column >= cfg.frame_columns || column == 9'd0) begin
					column = '0;
					row = row + 9'd1;
					if (row >= cfg.frame_rows || row == 9'd0) begin
						row = '0;
						item.done = 1'b1;
					end
				end
				expected.push_back(item);
			end
		endfunction

		function void check_result(logic [ADDR_W-1:0] addr, logic [COLOR_W-1:0] color,
				logic done);
			pixel_t want;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word addr=%h color=%h done=%b",
						$time, addr, color, done);
			end else begin
				want = expected.pop_front();
				if (addr !== want.addr || color !== want.color || done !== want.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch addr %h/%h color %h/%h done %b/%b (exp/act)",
							$time, want.addr, addr, want.color, color, want.done, done);
				end
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic write_enable;
	logic [REG_IDX_W-1:0] write_index;
	logic [DIM_W-1:0] write_data;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [7:0] code;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic out_valid;
	logic out_stall;
	logic [ADDR_W-1:0] pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic frame_done;

	pixel_scoreboard sb;
	int cycle_count = 0;
	bit palette_written [256];
	logic [7:0] written_codes [$];
	int send_count = 0;
	bit send_calm = 0;
	int recv_count = 0;
	bit recv_calm = 0;

	palette_rotating_pixel_blitter uut (
		.clk(clk),
		.arst_n(arst_n),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_data(write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.code(code),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_address(pixel_address),
		.pixel_color(pixel_color),
		.frame_done(frame_done)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(pixel_address, pixel_color, frame_done);
	end

	function int sender_wait();
		if (send_count % 50 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
		send_count++;
		return send_calm ? 0 : $urandom_range(0, 11);
	endfunction

	function int receiver_wait();
		if (recv_count % 50 == 0)
			recv_calm = ($urandom_range(0, 3) == 0);
		recv_count++;
		return recv_calm ? 0 : $urandom_range(0, 11);
	endfunction

	initial begin : receiver
		int n;
		@(posedge clk);
		forever begin
			n = receiver_wait();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_word(int gap, logic act, logic [7:0] cd, logic [7:0] r,
			logic [7:0] g, logic [7:0] b);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		code <= cd;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (in_stall);
		sb.note_word(act, cd, r, g, b);
	endtask

	task automatic write_palette(int gap, logic [7:0] cd, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		if (!palette_written[cd]) begin
			palette_written[cd] = 1'b1;
			written_codes.push_back(cd);
		end
		send_word(gap, ACT_PALETTE, cd, r, g, b);
	endtask

	task automatic random_word();
		logic [7:0] cd;
		if (written_codes.size() == 0 || $urandom_range(0, 3) == 0) begin
			write_palette(sender_wait(), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));
		end else begin
			cd = written_codes[$urandom_range(0, written_codes.size() - 1)];
			send_word(sender_wait(), ACT_PIXEL, cd, 8'($urandom), 8'($urandom),
				8'($urandom));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(cfg_t c);
		logic [DIM_W-1:0] v [7];
		v[0] = {7'($urandom), c.rotation};
		v[1] = c.screen_width;
		v[2] = c.screen_height;
		v[3] = c.frame_left;
		v[4] = c.frame_top;
		v[5] = c.frame_columns;
		v[6] = c.frame_rows;
		for (int i = 0; i < 7; i++) begin
			write_enable <= 1'b1;
			write_index <= REG_IDX_W'(i);
			write_data <= v[i];
			@(posedge clk);
			sb.set_reg(reg_index_t'(i), v[i]);
		end
		write_enable <= 1'b0;
	endtask

	function automatic cfg_t phase_setting(int p);
		cfg_t c;
		case (p)
			0: c = '{ROT_0, 9'd1, 9'd1, 9'd0, 9'd0, 9'd1, 9'd1};
			1: c = '{ROT_90, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511};
			2: c = '{ROT_180, 9'd511, 9'd1, 9'd0, 9'd511, 9'd5, 9'd3};
			3: c = '{ROT_270, 9'd1, 9'd511, 9'd511, 9'd0, 9'd7, 9'd2};
			4: c = '{ROT_90, 9'd300, 9'd200, 9'd17, 9'd9, 9'd0, 9'd0};
			default: begin
				c.rotation = rot_t'($urandom_range(0, 3));
				c.screen_width = 9'($urandom_range(1, 511));
				c.screen_height = 9'($urandom_range(1, 511));
				c.frame_left = 9'($urandom_range(0, 511));
				c.frame_top = 9'($urandom_range(0, 511));
				c.frame_columns = 9'($urandom_range(1, 9));
				c.frame_rows = 9'($urandom_range(1, 7));
			end
		endcase
		return c;
	endfunction

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		write_enable = 1'b0;
		write_index = '0;
		write_data = '0;
		in_valid = 1'b0;
		action = ACT_PIXEL;
		code = '0;
		red = '0;
		green = '0;
		blue = '0;
		out_stall = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Color extremes and a rewritten entry read in the very next cycle.
		write_palette(0, 8'h00, 8'h00, 8'h00, 8'h00);
		write_palette(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		write_palette(0, 8'hAA, 8'hAA, 8'h55, 8'hA5);
		write_palette(0, 8'h55, 8'h55, 8'hAA, 8'h5A);
		send_word(0, ACT_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		send_word(0, ACT_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_word(0, ACT_PIXEL, 8'hAA, 8'h00, 8'h00, 8'h00);
		send_word(0, ACT_PIXEL, 8'h55, 8'h00, 8'h00, 8'h00);
		write_palette(0, 8'h07, 8'hFF, 8'h00, 8'h00);
		send_word(0, ACT_PIXEL, 8'h07, 8'h00, 8'h00, 8'h00);
		write_palette(0, 8'h07, 8'h00, 8'hFF, 8'h00);
		send_word(0, ACT_PIXEL, 8'h07, 8'h00, 8'h00, 8'h00);
		write_palette(0, 8'h07, 8'h00, 8'h00, 8'hFF);
		send_word(0, ACT_PIXEL, 8'h07, 8'h00, 8'h00, 8'h00);
		send_word(3, ACT_PIXEL, 8'hFF, 8'h12, 8'h34, 8'h56);
		send_word(0, ACT_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			configure(phase_setting(p));
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if (p == 2 && i == 70)
					settle();
				random_word();
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
